### rtl/core/rgb_to_hsl_converter_core_defines.svh
// assertion macros for the rgb to hsl converter core
`ifndef RGB_TO_HSL_CONVERTER_CORE_DEFINES_SVH
`define RGB_TO_HSL_CONVERTER_CORE_DEFINES_SVH

// condition must hold at every edge out of reset
`define R2H_ASSERT(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("assertion failed");

// consequent must hold in the cycle after the antecedent
`define R2H_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

### rtl/core/r2h_pkg.sv
// package with payload types and constants of the rgb to hsl converter
`default_nettype none
package r2h_pkg;

  localparam int unsigned DivSteps = 15;
  localparam logic [8:0] FullSum = 9'd510;
  localparam logic [8:0] HalfSum = 9'd255;
  localparam logic signed [15:0] HueScale = 16'sd3840;

  typedef enum logic [1:0] {
    SectRed   = 2'd0,
    SectGreen = 2'd1,
    SectBlue  = 2'd2
  } sector_e;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] opacity;
  } pixel_in_t;

  typedef struct packed {
    logic signed [15:0] hue_deg_q6;
    logic [12:0]        saturation_q12;
    logic [8:0]         lightness_sum;
    logic [7:0]         opacity_out;
  } pixel_out_t;

endpackage
`default_nettype wire

### rtl/core/rgb_to_hsl_converter_core.sv
// top level of the rgb to hsl converter, a fully pipelined datapath
//
// input channel: in_valid_i / in_ready_o carry one rgba item per handshake
// output channel: out_valid_o / out_ready_i carry one hsl item per handshake
// stages from input accept to output valid: one min/max stage loaded at the
// accept edge, one setup stage, fifteen radix-2 divider stages shared by hue
// and saturation, one output register
// throughput: one item per cycle; every stage advances together
// when the receiver stalls, the whole pipeline holds and in_ready_o drops
// while the output register is full and not taken; nothing is lost or repeated
// reset: all valid bits clear, the pipeline is empty and ready at once
// no state links items, so every item is converted on its own
`default_nettype none
`include "rgb_to_hsl_converter_core_defines.svh"
module rgb_to_hsl_converter_core (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire r2h_pkg::pixel_in_t in_data_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output r2h_pkg::pixel_out_t     out_data_o
);
  import r2h_pkg::*;

  typedef struct packed {
    logic [7:0] mx;
    logic [7:0] mn;
    sector_e    sect;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] opacity;
  } stage_a_t;

  typedef struct packed {
    logic [7:0]  hrem;
    logic [14:0] hnq;
    logic [7:0]  hdiv;
    logic [7:0]  srem;
    logic [14:0] snq;
    logic [7:0]  sdiv;
    logic        grey;
    logic        satzero;
    logic [8:0]  sum;
    logic [7:0]  opacity;
  } div_t;

  function automatic logic [22:0] div_step(input logic [7:0] rem, input logic [14:0] nq,
                                           input logic [7:0] dv);
    logic [8:0] r2;
    logic [8:0] diff;
    r2   = {rem, nq[14]};
    diff = r2 - {1'b0, dv};
    if (r2 >= {1'b0, dv}) begin
      return {diff[7:0], nq[13:0], 1'b1};
    end else begin
      return {r2[7:0], nq[13:0], 1'b0};
    end
  endfunction

  logic                adv;
  logic                a_valid_q;
  stage_a_t            a_q, a_d;
  logic [DivSteps:0]   dv_valid_q;
  div_t                dv_q [DivSteps+1];
  div_t                dv0_d;
  div_t                dv_d [1:DivSteps];
  logic                out_valid_q;
  pixel_out_t          out_q, out_d;

  assign adv        = !out_valid_q || out_ready_i;
  assign in_ready_o = adv;

  // min, max and hue sector
  always_comb begin
    logic [7:0] mx;
    logic [7:0] mn;
    mx = in_data_i.red;
    mn = in_data_i.red;
    if (in_data_i.green > mx) mx = in_data_i.green;
    if (in_data_i.blue > mx)  mx = in_data_i.blue;
    if (in_data_i.green < mn) mn = in_data_i.green;
    if (in_data_i.blue < mn)  mn = in_data_i.blue;
    a_d.mx      = mx;
    a_d.mn      = mn;
    a_d.red     = in_data_i.red;
    a_d.green   = in_data_i.green;
    a_d.blue    = in_data_i.blue;
    a_d.opacity = in_data_i.opacity;
    if (mx == in_data_i.red && mx != in_data_i.green) begin
      a_d.sect = SectRed;
    end else if (mx == in_data_i.green && mx != in_data_i.blue) begin
      a_d.sect = SectGreen;
    end else begin
      a_d.sect = SectBlue;
    end
  end

  // divider setup
  always_comb begin
    logic [7:0]  d;
    logic [8:0]  sum;
    logic [8:0]  rest;
    logic [10:0] d11;
    logic [10:0] u;
    logic [22:0] hn;
    logic [19:0] sn;
    logic [7:0]  den;
    d    = a_q.mx - a_q.mn;
    sum  = {1'b0, a_q.mx} + {1'b0, a_q.mn};
    rest = FullSum - sum;
    d11  = {3'b0, d};
    case (a_q.sect)
      SectRed:   u = {3'b0, a_q.green} + d11 - {3'b0, a_q.blue};
      SectGreen: u = (d11 * 11'd3) + {3'b0, a_q.blue} - {3'b0, a_q.red};
      default:   u = (d11 * 11'd5) + {3'b0, a_q.red} - {3'b0, a_q.green};
    endcase
    hn  = ({12'b0, u} << 12) - ({12'b0, u} << 8);
    sn  = {d, 12'b0};
    den = (sum < HalfSum) ? sum[7:0] : rest[7:0];
    dv0_d.grey    = (d == 8'd0);
    dv0_d.satzero = (sum == 9'd0) || (sum == FullSum);
    dv0_d.hrem    = hn[22:15];
    dv0_d.hnq     = hn[14:0];
    dv0_d.hdiv    = (d == 8'd0) ? 8'd1 : d;
    dv0_d.srem    = {3'b0, sn[19:15]};
    dv0_d.snq     = sn[14:0];
    dv0_d.sdiv    = (den == 8'd0) ? 8'd1 : den;
    dv0_d.sum     = sum;
    dv0_d.opacity = a_q.opacity;
  end

  // one quotient bit per stage
  always_comb begin
    for (int k = 1; k <= DivSteps; k++) begin
      logic [22:0] hs;
      logic [22:0] ss;
      hs          = div_step(dv_q[k-1].hrem, dv_q[k-1].hnq, dv_q[k-1].hdiv);
      ss          = div_step(dv_q[k-1].srem, dv_q[k-1].snq, dv_q[k-1].sdiv);
      dv_d[k]      = dv_q[k-1];
      dv_d[k].hrem = hs[22:15];
      dv_d[k].hnq  = hs[14:0];
      dv_d[k].srem = ss[22:15];
      dv_d[k].snq  = ss[14:0];
    end
  end

  // result formatting
  always_comb begin
    out_d.hue_deg_q6     = dv_q[DivSteps].grey ? 16'sd0
                         : $signed({1'b0, dv_q[DivSteps].hnq}) - HueScale;
    out_d.saturation_q12 = dv_q[DivSteps].satzero ? 13'd0 : dv_q[DivSteps].snq[12:0];
    out_d.lightness_sum  = dv_q[DivSteps].sum;
    out_d.opacity_out    = dv_q[DivSteps].opacity;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q   <= 1'b0;
      dv_valid_q  <= '0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      a_valid_q   <= in_valid_i;
      dv_valid_q  <= {dv_valid_q[DivSteps-1:0], a_valid_q};
      out_valid_q <= dv_valid_q[DivSteps];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      a_q     <= a_d;
      out_q   <= out_d;
      dv_q[0] <= dv0_d;
      for (int k = 1; k <= DivSteps; k++) begin
        dv_q[k] <= dv_d[k];
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `R2H_ASSERT(sat_range_a, clk_i, rst_ni,
              !out_valid_q || out_q.saturation_q12 <= 13'd4096)
  `R2H_ASSERT(hue_range_a, clk_i, rst_ni,
              !out_valid_q || (out_q.hue_deg_q6 >= -16'sd3840 &&
                               out_q.hue_deg_q6 <= 16'sd19200))
  `R2H_ASSERT_NEXT(stall_hold_a, clk_i, rst_ni,
                   out_valid_q && !out_ready_i,
                   out_valid_q && !in_ready_o == !out_ready_i)

endmodule
`default_nettype wire

### sim/rgb_to_hsl_converter_core_tb.sv
// testbench for the rgb to hsl converter core: random and directed pixels against a local predictor
`default_nettype none
module rgb_to_hsl_converter_core_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import r2h_pkg::*;

  localparam int unsigned Latency = 17;
  localparam int unsigned WatchdogLimit = 20000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  pixel_in_t in_data_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  pixel_out_t out_data_o;

  rgb_to_hsl_converter_core dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .in_data_i(in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o(out_data_o)
  );

  always #5 clk_i = ~clk_i;

  pixel_in_t pending_pixels[$];
  pixel_out_t expected_hsl[$];
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  bit hold_sender = 1'b0;
  int unsigned mismatches = 0;
  int unsigned pixels_sent = 0;
  int unsigned pixels_checked = 0;
  int unsigned quiet_cycles = 0;
  bit saw_grey = 0, saw_neg_hue = 0, saw_full_sat = 0;

  function automatic pixel_out_t convert_pixel(pixel_in_t px);
    pixel_out_t res;
    int mx, mn, d, s, den, t, hue, sat;
    mx = px.red;
    mn = px.red;
    if (px.green > mx) mx = px.green;
    if (px.blue > mx) mx = px.blue;
    if (px.green < mn) mn = px.green;
    if (px.blue < mn) mn = px.blue;
    d = mx - mn;
    s = mx + mn;
    sat = 0;
    if (s > 0 && s < FullSum) begin
      den = (s < HalfSum) ? s : (FullSum - s);
      sat = (4096 * d) / den;
    end
    hue = 0;
    if (d > 0) begin
      if (mx == px.red && mx != px.green) t = int'(px.green) - int'(px.blue);
      else if (mx == px.green && mx != px.blue) t = 2 * d + int'(px.blue) - int'(px.red);
      else t = 4 * d + int'(px.red) - int'(px.green);
      hue = ((t + d) * 3840) / d - 3840;
    end
    res.hue_deg_q6 = hue[15:0];
    res.saturation_q12 = sat[12:0];
    res.lightness_sum = s[8:0];
    res.opacity_out = px.opacity;
    return res;
  endfunction

  // driver
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        expected_hsl.push_back(convert_pixel(in_data_i));
        pixels_sent++;
      end
      if (!(in_valid_i && !in_ready_o)) begin
        if (pending_pixels.size() > 0 && !hold_sender &&
            $urandom_range(99) >= send_idle_pct) begin
          in_data_i <= pending_pixels.pop_front();
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
      out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // monitor
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WatchdogLimit) begin
        $display("timeout: %0d cycles without a handshake", quiet_cycles);
        $display("FAIL rgb_to_hsl_converter_core");
        $finish;
      end
      if (out_valid_o && out_ready_i) begin
        pixel_out_t want;
        if (expected_hsl.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected item %p", out_data_o);
        end else begin
          want = expected_hsl.pop_front();
          pixels_checked++;
          if (out_data_o !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected h=%0d s=%0d l=%0d a=%0d got h=%0d s=%0d l=%0d a=%0d",
                       want.hue_deg_q6, want.saturation_q12, want.lightness_sum,
                       want.opacity_out, out_data_o.hue_deg_q6, out_data_o.saturation_q12,
                       out_data_o.lightness_sum, out_data_o.opacity_out);
          end
          if (want.hue_deg_q6 < 0) saw_neg_hue = 1;
          if (want.saturation_q12 == 13'd4096) saw_full_sat = 1;
          if (want.lightness_sum != 0 && want.hue_deg_q6 == 0 && want.saturation_q12 == 0)
            saw_grey = 1;
        end
      end
    end
  end

  function automatic pixel_in_t make_pixel(int r, int g, int b, int a);
    pixel_in_t px;
    px.red = r[7:0];
    px.green = g[7:0];
    px.blue = b[7:0];
    px.opacity = a[7:0];
    return px;
  endfunction

  function automatic pixel_in_t random_pixel();
    pixel_in_t px;
    int unsigned kind;
    px = pixel_in_t'($urandom);
    kind = $urandom_range(9);
    // ties and near-greys hit the sector and divider corners
    if (kind == 0) px.green = px.red;
    else if (kind == 1) px.blue = px.red;
    else if (kind == 2) px.blue = px.green;
    else if (kind == 3) begin
      px.green = px.red ^ 8'($urandom_range(3));
      px.blue = px.red ^ 8'($urandom_range(3));
    end else if (kind == 4) px.red = 8'($urandom_range(1) * 255);
    return px;
  endfunction

  task automatic drain();
    while (pending_pixels.size() > 0 || in_valid_i || expected_hsl.size() > 0)
      @(posedge clk_i);
  endtask

  initial begin
    int unsigned phase_pct[4][2] = '{'{0, 0}, '{68, 0}, '{0, 68}, '{25, 25}};
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // black, white, grey, primaries, secondaries, tie rules, negative hue
    pending_pixels.push_back(make_pixel(0, 0, 0, 0));
    pending_pixels.push_back(make_pixel(255, 255, 255, 255));
    pending_pixels.push_back(make_pixel(128, 128, 128, 170));
    pending_pixels.push_back(make_pixel(255, 0, 0, 85));
    pending_pixels.push_back(make_pixel(0, 255, 0, 1));
    pending_pixels.push_back(make_pixel(0, 0, 255, 254));
    pending_pixels.push_back(make_pixel(255, 255, 0, 0));
    pending_pixels.push_back(make_pixel(0, 255, 255, 0));
    pending_pixels.push_back(make_pixel(255, 0, 255, 0));
    pending_pixels.push_back(make_pixel(255, 0, 1, 0));
    pending_pixels.push_back(make_pixel(200, 10, 200, 0));
    pending_pixels.push_back(make_pixel(1, 0, 0, 0));
    pending_pixels.push_back(make_pixel(255, 254, 254, 0));
    pending_pixels.push_back(make_pixel(128, 127, 127, 0));
    pending_pixels.push_back(make_pixel(127, 128, 127, 0));
    pending_pixels.push_back(make_pixel(0, 1, 255, 0));
    pending_pixels.push_back(make_pixel(254, 255, 1, 0));
    pending_pixels.push_back(make_pixel(3, 2, 1, 0));
    pending_pixels.push_back(make_pixel(170, 85, 170, 255));
    pending_pixels.push_back(make_pixel(255, 1, 0, 128));

    foreach (phase_pct[p]) begin
      send_idle_pct = phase_pct[p][0];
      recv_stall_pct = phase_pct[p][1];
      for (int i = 0; i < 220; i++) pending_pixels.push_back(random_pixel());
      // pause the sender once so the pipeline empties completely
      while (pending_pixels.size() > 110) @(posedge clk_i);
      hold_sender = 1'b1;
      while (in_valid_i || expected_hsl.size() > 0) @(posedge clk_i);
      hold_sender = 1'b0;
      drain();
    end

    repeat (Latency + 4) @(posedge clk_i);
    $display("sent %0d pixels, checked %0d over four idle/stall mixes", pixels_sent,
             pixels_checked);
    $display("grey seen %0d, negative hue seen %0d, full saturation seen %0d", saw_grey,
             saw_neg_hue, saw_full_sat);
    if (mismatches == 0 && expected_hsl.size() == 0) begin
      $display("PASS rgb_to_hsl_converter_core");
    end else begin
      $display("%0d mismatches, %0d items still expected", mismatches, expected_hsl.size());
      $display("FAIL rgb_to_hsl_converter_core");
    end
    $finish;
  end
endmodule
`default_nettype wire

### filelist.f
+incdir+rtl/core
rtl/core/r2h_pkg.sv
rtl/core/rgb_to_hsl_converter_core.sv
sim/rgb_to_hsl_converter_core_tb.sv
